### hw/rtl/drt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the dirty rectangle tracker
// Holds the rectangle type, request, status and register codes, and the
// controller state type used by the tracker and its storage cells.
// ----------------------------------------------------------------------------
package drt_pkg;

    // Coordinate width of every rectangle edge.
    localparam int CRD_W = 16;

    // Default number of table entries.
    localparam int TABLE_DEPTH_DEF = 32;

    // Reset values of the screen rectangle registers.
    localparam logic signed [CRD_W-1:0] SCREEN_X1_RST = 16'sd0;
    localparam logic signed [CRD_W-1:0] SCREEN_Y1_RST = 16'sd0;
    localparam logic signed [CRD_W-1:0] SCREEN_X2_RST = 16'sd319;
    localparam logic signed [CRD_W-1:0] SCREEN_Y2_RST = 16'sd239;

    // Request types.
    localparam logic [1:0] REQ_INVALIDATE = 2'd0;
    localparam logic [1:0] REQ_CLEAR      = 2'd1;
    localparam logic [1:0] REQ_REFRESH    = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_COVERED = 3'd1;
    localparam logic [2:0] ST_OFF     = 3'd2;
    localparam logic [2:0] ST_WRAPPED = 3'd3;
    localparam logic [2:0] ST_REFRESH = 3'd4;

    // Register word indexes on the configuration port.
    localparam logic [1:0] REG_SCREEN_X1 = 2'd0;
    localparam logic [1:0] REG_SCREEN_Y1 = 2'd1;
    localparam logic [1:0] REG_SCREEN_X2 = 2'd2;
    localparam logic [1:0] REG_SCREEN_Y2 = 2'd3;

    // An inclusive rectangle.
    typedef struct packed {
        logic signed [CRD_W-1:0] x1;
        logic signed [CRD_W-1:0] y1;
        logic signed [CRD_W-1:0] x2;
        logic signed [CRD_W-1:0] y2;
    } t_rect;

    // Per-cell control from the tracker controller.
    typedef struct packed {
        logic shift;  // take the neighbour's rectangle
        logic wr;     // store the broadcast rectangle
        logic used;   // entry lies below the fill count
    } t_cell_ctrl;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DRAIN
    } t_state;

endpackage

### hw/rtl/dirty_rect_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_rect_tracker: table of invalidated screen rectangles
// Clips invalidate requests to the screen, drops covered ones, appends the
// rest to a chain of entry cells and drains the chain on refresh.
// ----------------------------------------------------------------------------
// An invalidate request: the cycle of acceptance clips the area against the
// screen rectangle into a register, and the check state, entered in the next
// cycle, tests it against every entry of the cell chain at once and stores it
// unless it is off the screen or covered. A clear request gives no result.
// A refresh request drains the table: the entries leave one per cycle from
// cell zero while the chain shifts towards it, unless the result side stalls.
// A stalled result holds the block in its current step. No clearing pass is
// needed after reset: the fill count alone marks which entries are in use.
module dirty_rect_tracker #(
    parameter int TABLE_DEPTH = drt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Request channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_req_type,
    input  logic signed [drt_pkg::CRD_W-1:0] i_area_x1,
    input  logic signed [drt_pkg::CRD_W-1:0] i_area_y1,
    input  logic signed [drt_pkg::CRD_W-1:0] i_area_x2,
    input  logic signed [drt_pkg::CRD_W-1:0] i_area_y2,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_status,
    output logic signed [drt_pkg::CRD_W-1:0] o_out_x1,
    output logic signed [drt_pkg::CRD_W-1:0] o_out_y1,
    output logic signed [drt_pkg::CRD_W-1:0] o_out_x2,
    output logic signed [drt_pkg::CRD_W-1:0] o_out_y2,
    output logic                            o_last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    // Screen rectangle registers.
    logic signed [drt_pkg::CRD_W-1:0] r_scr_x1;
    logic signed [drt_pkg::CRD_W-1:0] r_scr_y1;
    logic signed [drt_pkg::CRD_W-1:0] r_scr_x2;
    logic signed [drt_pkg::CRD_W-1:0] r_scr_y2;
    logic                             w_cfg_wr;
    logic [drt_pkg::CRD_W-1:0]        w_rd_val;

    // Controller state.
    drt_pkg::t_state  r_state;
    drt_pkg::t_state  n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_remain;
    logic [CNT_W-1:0] n_remain;
    logic [CNT_W-1:0] w_wpos;

    // Clipped request.
    drt_pkg::t_rect r_clip;
    drt_pkg::t_rect n_clip;
    logic           r_off;
    logic           n_off;

    // Result register.
    logic           r_out_valid;
    logic           n_out_valid;
    logic [2:0]     r_status;
    logic [2:0]     n_status;
    drt_pkg::t_rect r_out_rect;
    drt_pkg::t_rect n_out_rect;
    logic           r_last;
    logic           n_last;

    // Handshake and chain controls.
    logic           w_accept;
    logic           w_out_free;
    logic           w_shift;
    logic           w_wr_en;
    drt_pkg::t_rect w_rect [TABLE_DEPTH];
    logic           w_hit  [TABLE_DEPTH+1];

    // Configuration writes and reads.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_x1 <= drt_pkg::SCREEN_X1_RST;
            r_scr_y1 <= drt_pkg::SCREEN_Y1_RST;
            r_scr_x2 <= drt_pkg::SCREEN_X2_RST;
            r_scr_y2 <= drt_pkg::SCREEN_Y2_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                drt_pkg::REG_SCREEN_X1: r_scr_x1 <= pwdata[15:0];
                drt_pkg::REG_SCREEN_Y1: r_scr_y1 <= pwdata[15:0];
                drt_pkg::REG_SCREEN_X2: r_scr_x2 <= pwdata[15:0];
                drt_pkg::REG_SCREEN_Y2: r_scr_y2 <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            drt_pkg::REG_SCREEN_X1: w_rd_val = r_scr_x1;
            drt_pkg::REG_SCREEN_Y1: w_rd_val = r_scr_y1;
            drt_pkg::REG_SCREEN_X2: w_rd_val = r_scr_x2;
            drt_pkg::REG_SCREEN_Y2: w_rd_val = r_scr_y2;
            default:                w_rd_val = '0;
        endcase
    end

    assign prdata = {{16{w_rd_val[15]}}, w_rd_val};

    // Clip the requested area against the screen rectangle.
    always_comb begin
        n_clip.x1 = (i_area_x1 > r_scr_x1) ? i_area_x1 : r_scr_x1;
        n_clip.y1 = (i_area_y1 > r_scr_y1) ? i_area_y1 : r_scr_y1;
        n_clip.x2 = (i_area_x2 < r_scr_x2) ? i_area_x2 : r_scr_x2;
        n_clip.y2 = (i_area_y2 < r_scr_y2) ? i_area_y2 : r_scr_y2;
        n_off     = (n_clip.x1 > n_clip.x2) || (n_clip.y1 > n_clip.y2);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_clip <= n_clip;
            r_off  <= n_off;
        end
    end

    // Handshakes.
    assign o_in_stall = (r_state != drt_pkg::S_IDLE);
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    // A full table restarts at the first entry.
    assign w_wpos = (r_count == FULL) ? '0 : r_count;

    // Next state, table controls and result.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_remain    = r_remain;
        n_out_valid = r_out_valid & i_out_stall;
        n_status    = r_status;
        n_out_rect  = r_out_rect;
        n_last      = r_last;
        w_shift     = 1'b0;
        w_wr_en     = 1'b0;
        case (r_state)
            drt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        drt_pkg::REQ_INVALIDATE: n_state = drt_pkg::S_CHECK;
                        drt_pkg::REQ_CLEAR:      n_count = '0;
                        drt_pkg::REQ_REFRESH: begin
                            if (r_count != '0) begin
                                n_remain = r_count;
                                n_state  = drt_pkg::S_DRAIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            drt_pkg::S_CHECK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_last      = 1'b1;
                    n_state     = drt_pkg::S_IDLE;
                    if (r_off) begin
                        n_status   = drt_pkg::ST_OFF;
                        n_out_rect = '0;
                    end else if (w_hit[0]) begin
                        n_status   = drt_pkg::ST_COVERED;
                        n_out_rect = r_clip;
                    end else begin
                        w_wr_en    = 1'b1;
                        n_status   = (r_count == FULL) ? drt_pkg::ST_WRAPPED
                                                       : drt_pkg::ST_ADDED;
                        n_out_rect = r_clip;
                        n_count    = w_wpos + ONE;
                    end
                end
            end
            drt_pkg::S_DRAIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = drt_pkg::ST_REFRESH;
                    n_out_rect  = w_rect[0];
                    n_last      = (r_remain == ONE);
                    w_shift     = 1'b1;
                    n_remain    = r_remain - ONE;
                    if (r_remain == ONE) begin
                        n_count = '0;
                        n_state = drt_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = drt_pkg::S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= drt_pkg::S_IDLE;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_out_rect <= n_out_rect;
        r_last     <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_x1    = r_out_rect.x1;
    assign o_out_y1    = r_out_rect.y1;
    assign o_out_x2    = r_out_rect.x2;
    assign o_out_y2    = r_out_rect.y2;
    assign o_last      = r_last;

    // Chain of entry cells; data and hits flow towards cell zero.
    assign w_hit[TABLE_DEPTH] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        drt_pkg::t_cell_ctrl w_ctrl;
        drt_pkg::t_rect      w_next;

        assign w_ctrl.shift = w_shift;
        assign w_ctrl.wr    = w_wr_en && (w_wpos == CNT_W'(g));
        assign w_ctrl.used  = (r_count > CNT_W'(g));

        if (g == TABLE_DEPTH - 1) begin : g_end
            assign w_next = w_rect[g];
        end else begin : g_mid
            assign w_next = w_rect[g+1];
        end

        drt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_wr_rect   (r_clip),
            .i_next_rect (w_next),
            .i_chk_rect  (r_clip),
            .i_hit       (w_hit[g+1]),
            .o_rect      (w_rect[g]),
            .o_hit       (w_hit[g])
        );
    end

`ifndef SYNTHESIS
    // The fill count never passes the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count beyond table depth");

    // A drain always has entries left, and no more than the table holds.
    a_drain_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drt_pkg::S_DRAIN) |-> (r_remain != '0) && (r_remain <= r_count))
        else $error("drain counter out of range");

    // The final drained entry empties the table and returns to idle.
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drt_pkg::S_DRAIN) && w_out_free && (r_remain == ONE)
        |=> (r_count == '0) && (r_state == drt_pkg::S_IDLE) && o_last)
        else $error("drain did not finish cleanly");

    // An accepted invalidate request is checked in the following cycle.
    a_inval_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_req_type == drt_pkg::REQ_INVALIDATE)
        |=> (r_state == drt_pkg::S_CHECK))
        else $error("invalidate request not checked");
`endif

endmodule

### hw/rtl/drt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_cell: one table entry of the dirty rectangle tracker
// Stores one rectangle, tests a broadcast rectangle for containment and
// passes the hit and its stored rectangle on towards cell zero.
// ----------------------------------------------------------------------------
module drt_cell (
    input  logic                 i_clk,
    input  drt_pkg::t_cell_ctrl  i_ctrl,
    input  drt_pkg::t_rect       i_wr_rect,
    input  drt_pkg::t_rect       i_next_rect,
    input  drt_pkg::t_rect       i_chk_rect,
    input  logic                 i_hit,
    output drt_pkg::t_rect       o_rect,
    output logic                 o_hit
);

    drt_pkg::t_rect r_rect;
    drt_pkg::t_rect n_rect;
    logic           w_inside;

    // Next content: a new entry, the neighbour's entry during a drain, or hold.
    always_comb begin
        n_rect = r_rect;
        if (i_ctrl.wr) begin
            n_rect = i_wr_rect;
        end else if (i_ctrl.shift) begin
            n_rect = i_next_rect;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rect <= n_rect;
    end

    // The checked rectangle lies wholly inside the stored one.
    assign w_inside = (i_chk_rect.x1 >= r_rect.x1) && (i_chk_rect.y1 >= r_rect.y1) &&
                      (i_chk_rect.x2 <= r_rect.x2) && (i_chk_rect.y2 <= r_rect.y2);

    // Hits collect along the chain; only entries in use take part.
    assign o_hit  = i_hit | (i_ctrl.used & w_inside);
    assign o_rect = r_rect;

endmodule

### dv/dirty_rect_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_rect_tracker_tb: self-checking testbench of the dirty rectangle tracker
// Drives invalidate, clear and refresh requests, mostly under random idling on
// both sides. It predicts every result from its own copy of the rectangle table
// and the screen registers, and compares each result field by field in order.
// ----------------------------------------------------------------------------

import drt_pkg::*;

typedef logic signed [CRD_W-1:0] coord_t;

// An inclusive rectangle as the testbench keeps it.
typedef struct {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
} box_t;

// One result that the tracker still owes.
typedef struct {
    logic [2:0] status;
    box_t       r;
    logic       last_flag;
} rect_result_t;

// Tracks the rectangle table and the screen, and checks the results against it.
class dirty_rect_scoreboard;
    box_t         screen;
    box_t         entries[TABLE_DEPTH_DEF];
    int           fill;
    rect_result_t awaited[$];
    int           errors;

    function new();
        screen = '{SCREEN_X1_RST, SCREEN_Y1_RST, SCREEN_X2_RST, SCREEN_Y2_RST};
        fill   = 0;
        errors = 0;
    endfunction

    function void set_screen(logic [1:0] idx, coord_t value);
        case (idx)
            REG_SCREEN_X1: screen.x1 = value;
            REG_SCREEN_Y1: screen.y1 = value;
            REG_SCREEN_X2: screen.x2 = value;
            REG_SCREEN_Y2: screen.y2 = value;
            default: ;
        endcase
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void queue_result(logic [2:0] status, box_t r, logic last_flag);
        rect_result_t res;
        res.status    = status;
        res.r         = r;
        res.last_flag = last_flag;
        awaited.push_back(res);
    endfunction

    // Works out the results of one accepted request and updates the table.
    function void note_request(logic [1:0] kind, box_t area);
        box_t       clip;
        logic       covered;
        logic [2:0] status;
        case (kind)
            REQ_INVALIDATE: begin
                clip.x1 = (area.x1 > screen.x1) ? area.x1 : screen.x1;
                clip.y1 = (area.y1 > screen.y1) ? area.y1 : screen.y1;
                clip.x2 = (area.x2 < screen.x2) ? area.x2 : screen.x2;
                clip.y2 = (area.y2 < screen.y2) ? area.y2 : screen.y2;
                if (clip.x1 > clip.x2 || clip.y1 > clip.y2) begin
                    queue_result(ST_OFF, '{default: '0}, 1'b1);
                end else begin
                    covered = 1'b0;
                    for (int i = 0; i < fill; i++) begin
                        if (clip.x1 >= entries[i].x1 && clip.y1 >= entries[i].y1 &&
                            clip.x2 <= entries[i].x2 && clip.y2 <= entries[i].y2)
                            covered = 1'b1;
                    end
                    if (covered) begin
                        queue_result(ST_COVERED, clip, 1'b1);
                    end else begin
                        // A full table starts again from its first entry.
                        status = ST_ADDED;
                        if (fill >= TABLE_DEPTH_DEF) begin
                            fill   = 0;
                            status = ST_WRAPPED;
                        end
                        entries[fill] = clip;
                        fill++;
                        queue_result(status, clip, 1'b1);
                    end
                end
            end
            REQ_CLEAR: fill = 0;
            REQ_REFRESH: begin
                for (int i = 0; i < fill; i++)
                    queue_result(ST_REFRESH, entries[i], i == fill - 1);
                fill = 0;
            end
            default: ;
        endcase
    endfunction

    function void compare_field(string field, logic signed [31:0] want,
                                logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    // Compares one accepted result with the oldest one owed.
    function void check_result(logic [2:0] status, box_t r, logic last_flag);
        rect_result_t want;
        if (awaited.size() == 0) begin
            $error("result with no request owing it: status %0d", status);
            errors++;
            return;
        end
        want = awaited.pop_front();
        compare_field("status", want.status, status);
        compare_field("out_x1", want.r.x1, r.x1);
        compare_field("out_y1", want.r.y1, r.y1);
        compare_field("out_x2", want.r.x2, r.x2);
        compare_field("out_y2", want.r.y2, r.y2);
        compare_field("last", want.last_flag, last_flag);
    endfunction
endclass

module dirty_rect_tracker_tb;

    localparam int         CLK_PERIOD    = 4;
    localparam int         TABLE_DEPTH   = TABLE_DEPTH_DEF;
    localparam int         SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int         CYCLE_LIMIT   = 600000;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         i_in_valid;
    logic         o_in_stall;
    logic [1:0]   i_req_type;
    coord_t       i_area_x1;
    coord_t       i_area_y1;
    coord_t       i_area_x2;
    coord_t       i_area_y2;
    logic         o_out_valid;
    logic         i_out_stall;
    logic [2:0]   o_status;
    coord_t       o_out_x1;
    coord_t       o_out_y1;
    coord_t       o_out_x2;
    coord_t       o_out_y2;
    logic         o_last;

    dirty_rect_scoreboard tracker;
    box_t                 recent[$];
    int                   issued      = 0;
    int                   cycle_count = 0;
    int                   hold_cycles = 0;
    bit                   src_gaps    = 1'b1;
    bit                   sink_gaps   = 1'b1;

    dirty_rect_tracker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Give up on a hung run.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("dirty_rect_tracker verification failed");
        $finish;
    end

    // Both handshakes are sampled with the values they held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                tracker.note_request(i_req_type,
                    box_t'{i_area_x1, i_area_y1, i_area_x2, i_area_y2});
            if (o_out_valid && !i_out_stall)
                tracker.check_result(o_status,
                    box_t'{o_out_x1, o_out_y1, o_out_x2, o_out_y2}, o_last);
        end
    end

    // The result side stalls in random bursts, or for one long hold when asked.
    initial begin : result_sink
        int n;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic box_t make_box(int x1, int y1, int x2, int y2);
        box_t b;
        b.x1 = CRD_W'(x1);
        b.y1 = CRD_W'(y1);
        b.x2 = CRD_W'(x2);
        b.y2 = CRD_W'(y2);
        return b;
    endfunction

    // Uniform coordinate between two bounds, kept within the 16-bit range.
    function automatic int pick_coord(int lo, int hi);
        int t;
        if (lo < -32768) lo = -32768;
        if (lo > 32767)  lo = 32767;
        if (hi < -32768) hi = -32768;
        if (hi > 32767)  hi = 32767;
        if (hi < lo) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Offers one request and returns once it has been taken.
    task automatic issue_request(input logic [1:0] kind, input box_t area);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_area_x1  <= area.x1;
        i_area_y1  <= area.y1;
        i_area_x2  <= area.x2;
        i_area_y2  <= area.y2;
        do @(posedge i_clk); while (o_in_stall);
        if (kind != REQ_UNUSED)
            issued++;
    endtask

    // Holds the request side idle until every owed result has arrived.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup phase, access phase, then idle.
    task automatic write_screen(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_screen(idx, CRD_W'(value));
        @(posedge i_clk);
    endtask

    task automatic program_screen(input int x1, input int y1, input int x2, input int y2);
        wait_drained();
        write_screen(REG_SCREEN_X1, x1);
        write_screen(REG_SCREEN_Y1, y1);
        write_screen(REG_SCREEN_X2, x2);
        write_screen(REG_SCREEN_Y2, y2);
    endtask

    // Clears the table, fills it with n single-column strips that cannot cover
    // one another, and drains it with a refresh.
    task automatic fill_strips(input int n);
        int sx1, sy1, sy2, y1, k;
        sx1 = tracker.screen.x1;
        sy1 = tracker.screen.y1;
        sy2 = tracker.screen.y2;
        issue_request(REQ_CLEAR, make_box(0, 0, 0, 0));
        recent.delete();
        for (k = 0; k < n; k++) begin
            y1 = pick_coord(sy1, sy2);
            issue_request(REQ_INVALIDATE,
                make_box(sx1 + k, y1, sx1 + k, pick_coord(y1, sy2 + 8)));
        end
        issue_request(REQ_REFRESH, make_box(0, 0, 0, 0));
    endtask

    // A run of mostly invalidate requests, often closed by a refresh or a clear.
    task automatic run_episode(input int len);
        box_t r;
        int   sx1, sy1, sx2, sy2, wx, wy, k, pick;
        int   x1, y1, x2, y2;
        sx1 = tracker.screen.x1;
        sy1 = tracker.screen.y1;
        sx2 = tracker.screen.x2;
        sy2 = tracker.screen.y2;
        wx  = (sx2 > sx1) ? (sx2 - sx1) / 4 + 1 : 64;
        wy  = (sy2 > sy1) ? (sy2 - sy1) / 4 + 1 : 64;
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 19);
            if (pick >= 11 && pick < 15 && recent.size() == 0)
                pick = 0;
            if (pick < 11) begin
                // Fresh area near the screen, often reaching past an edge.
                x1 = pick_coord(sx1 - 16, sx2);
                y1 = pick_coord(sy1 - 16, sy2);
                x2 = pick_coord(x1, x1 + int'($urandom_range(0, wx)));
                y2 = pick_coord(y1, y1 + int'($urandom_range(0, wy)));
                recent.push_back(make_box(x1, y1, x2, y2));
                issue_request(REQ_INVALIDATE, make_box(x1, y1, x2, y2));
            end else if (pick < 15) begin
                // Part of an area sent earlier, so most likely covered.
                r  = recent[$urandom_range(0, recent.size() - 1)];
                x1 = pick_coord(r.x1, r.x2);
                y1 = pick_coord(r.y1, r.y2);
                x2 = pick_coord(x1, r.x2);
                y2 = pick_coord(y1, r.y2);
                issue_request(REQ_INVALIDATE, make_box(x1, y1, x2, y2));
            end else if (pick < 17) begin
                // Area wholly beside the screen, or with its edges swapped.
                x1 = pick_coord(-32768, 32767);
                y1 = pick_coord(-32768, 32767);
                x2 = pick_coord(-32768, 32767);
                y2 = pick_coord(-32768, 32767);
                case ($urandom_range(0, 3))
                    0: begin
                        x2 = pick_coord(-32768, sx1 - 1);
                        x1 = pick_coord(-32768, x2);
                    end
                    1: begin
                        y1 = pick_coord(sy2 + 1, 32767);
                        y2 = pick_coord(y1, 32767);
                    end
                    2: begin
                        x2 = pick_coord(-32768, 32766);
                        x1 = pick_coord(x2 + 1, 32767);
                    end
                    default: begin
                        x1 = pick_coord(sx2 + 1, 32767);
                        x2 = pick_coord(x1, 32767);
                    end
                endcase
                issue_request(REQ_INVALIDATE, make_box(x1, y1, x2, y2));
            end else if (pick < 18) begin
                // Any bit pattern at all.
                issue_request(REQ_INVALIDATE,
                    make_box(pick_coord(-32768, 32767), pick_coord(-32768, 32767),
                             pick_coord(-32768, 32767), pick_coord(-32768, 32767)));
            end else if (pick < 19) begin
                issue_request(REQ_UNUSED,
                    make_box(pick_coord(-32768, 32767), pick_coord(-32768, 32767),
                             pick_coord(-32768, 32767), pick_coord(-32768, 32767)));
            end else begin
                issue_request(REQ_CLEAR, make_box(0, 0, 0, 0));
                recent.delete();
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            issue_request(REQ_REFRESH, make_box(0, 0, 0, 0));
            recent.delete();
        end else if (pick < 8) begin
            issue_request(REQ_CLEAR, make_box(0, 0, 0, 0));
            recent.delete();
        end
    endtask

    // Random episodes until about the given number of requests have gone in.
    task automatic run_random(input int target, input bit allow_gaps);
        int stop, len;
        stop = issued + target;
        while (issued < stop) begin
            src_gaps  = allow_gaps && ($urandom_range(0, 3) != 0);
            sink_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
            len       = $urandom_range(1, 40);
            if (len > stop - issued)
                len = stop - issued;
            run_episode(len);
        end
    endtask

    initial begin : stimulus
        int x1, y1;
        tracker = new();
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_req_type <= REQ_INVALIDATE;
        i_area_x1  <= '0;
        i_area_y1  <= '0;
        i_area_x2  <= '0;
        i_area_y2  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests against the screen left at its reset value.
        issue_request(REQ_REFRESH,    make_box(0, 0, 0, 0));
        issue_request(REQ_INVALIDATE, make_box(0, 0, 319, 239));
        issue_request(REQ_INVALIDATE, make_box(10, 10, 20, 20));
        issue_request(REQ_INVALIDATE, make_box(-32768, -32768, 32767, 32767));
        issue_request(REQ_INVALIDATE, make_box(320, 0, 400, 10));
        issue_request(REQ_INVALIDATE, make_box(-50, -50, -1, -1));
        issue_request(REQ_INVALIDATE, make_box(5, 5, 4, 4));
        issue_request(REQ_INVALIDATE, make_box(0, 240, 319, 32767));
        issue_request(REQ_UNUSED,     make_box(32767, -32768, -1, 21845));
        issue_request(REQ_CLEAR,      make_box(0, 0, 0, 0));
        issue_request(REQ_REFRESH,    make_box(0, 0, 0, 0));
        issue_request(REQ_INVALIDATE, make_box(100, 100, 100, 100));
        issue_request(REQ_INVALIDATE, make_box(319, 239, 319, 239));
        issue_request(REQ_INVALIDATE, make_box(0, 0, 10, 10));
        issue_request(REQ_INVALIDATE, make_box(100, 100, 100, 100));
        issue_request(REQ_INVALIDATE, make_box(-32768, 0, 32767, 0));
        issue_request(REQ_INVALIDATE, make_box(5, 0, 9, 0));
        issue_request(REQ_REFRESH,    make_box(0, 0, 0, 0));
        issue_request(REQ_INVALIDATE, make_box(32767, 32767, -32768, -32768));
        issue_request(REQ_REFRESH,    make_box(0, 0, 0, 0));

        // Screen spanning the whole coordinate range.
        program_screen(-32768, -32768, 32767, 32767);
        run_random(30, 1'b1);

        // Screen with its edges swapped: nothing can land, old entries remain.
        program_screen(32767, 32767, -32768, -32768);
        run_random(12, 1'b1);

        // Small screen at a random place.
        x1 = pick_coord(-500, 500);
        y1 = pick_coord(-500, 500);
        program_screen(x1, y1, x1 + int'($urandom_range(40, 600)),
                       y1 + int'($urandom_range(40, 600)));
        run_random(20, 1'b1);

        // The result side holds off while a full table is filled and drained.
        src_gaps    = 1'b0;
        hold_cycles = 300;
        fill_strips(TABLE_DEPTH);

        // The request side waits for every result before going on.
        wait_drained();
        run_random(20, 1'b1);

        // Reset screen again, with no idling from here on, past a table wrap.
        program_screen(SCREEN_X1_RST, SCREEN_Y1_RST, SCREEN_X2_RST, SCREEN_Y2_RST);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        fill_strips(TABLE_DEPTH + 1 + $urandom_range(0, 6));
        run_random(25, 1'b0);

        wait_drained();
        if (tracker.errors == 0)
            $display("dirty_rect_tracker verification clean");
        else
            $display("dirty_rect_tracker verification failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/drt_pkg.sv
hw/rtl/drt_cell.sv
hw/rtl/dirty_rect_tracker.sv
dv/dirty_rect_tracker_tb.sv
